// ===== rtl/dltq_pkg.sv =====
// ---------------------------------------------------------------------------
// dltq_pkg: shared types and constants of the delta-list timer queue
// Item and result layouts, queue entry, sequencer states.
// ---------------------------------------------------------------------------
package dltq_pkg;

    localparam int TIMER_SLOTS = 16;
    localparam int TICK_WIDTH  = 32;
    localparam int MAX_RESULTS = 16;
    localparam int SLOT_W      = $clog2(TIMER_SLOTS + 1);
    localparam int SIDX_W      = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
    localparam int RCNT_W      = $clog2(MAX_RESULTS + 1);
    localparam logic [SLOT_W-1:0] NIL = SLOT_W'(TIMER_SLOTS);
    localparam logic [TICK_WIDTH-1:0] TICK_MAX = '1;

    typedef enum logic [1:0] {
        KIND_ADDED   = 2'd0,
        KIND_FULL    = 2'd1,
        KIND_EXPIRED = 2'd2
    } kind_t;

    typedef struct packed {
        logic        action;
        logic [31:0] period;
        logic        reload;
        logic [15:0] tag;
    } item_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] expired_tag;
        logic        was_reload;
        logic        last;
    } result_t;

    // Classified command handed from the front end to the list engine.
    typedef struct packed {
        logic                  is_add;
        logic [TICK_WIDTH-1:0] ticks;
        logic                  reload;
        logic [15:0]           tag;
    } cmd_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ADD,
        ST_DEC,
        ST_EXP_OS,
        ST_EXP_RL,
        ST_RL_FLAG,
        ST_INS_INIT,
        ST_INS_WALK,
        ST_INS_LINK,
        ST_DONE
    } state_t;

endpackage

// ===== rtl/delta_list_timer_queue_unit.sv =====
// ---------------------------------------------------------------------------
// delta_list_timer_queue_unit: two delta-sorted timer lists over one slot pool
// Front end queues tick and add commands; the engine walks the lists.
// ---------------------------------------------------------------------------
//  channel   handshake           payload
//  command   start & !busy       item   (item_t)
//  result    strobe, one cycle   result (result_t)
//
// An add takes a free slot and walks the target list, at most TIMER_SLOTS
// entries, or gives a full result when the pool is full. A tick decrements
// both list heads, expires the one-shot heads, then expires each reload
// head and walks it back into the reload list.
// Reset clears the slot-used mask and both list heads; slot storage is
// written when a slot is taken. busy rises only when the two-entry
// command queue is full. The receiver cannot stall: results leave on
// strobe, at most one per cycle, the last of each item flagged.
// ---------------------------------------------------------------------------
module delta_list_timer_queue_unit import dltq_pkg::*; (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    input  item_t   item,
    output logic    busy,
    output logic    strobe,
    output result_t result
);
    logic    q_full, q_empty, q_pop, eng_strobe;
    cmd_t    q_head;
    result_t eng_res;

    // Intake: classify and hold up to two transactions.
    dltq_front u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (start && !busy),
        .item  (item),
        .pop   (q_pop),
        .full  (q_full),
        .empty (q_empty),
        .head  (q_head)
    );

    // Back end: carry out one command at a time.
    dltq_engine u_engine (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (!q_empty),
        .cmd        (q_head),
        .cmd_pop    (q_pop),
        .res_strobe (eng_strobe),
        .res        (eng_res)
    );

    assign busy = q_full;

    // Results come straight from the engine's output register.
    assign strobe = eng_strobe;
    assign result = eng_res;
endmodule

// ===== rtl/dltq_front.sv =====
// ---------------------------------------------------------------------------
// dltq_front: command intake
// Saturate and fix up periods, then push the command into a two-entry queue.
// ---------------------------------------------------------------------------
module dltq_front import dltq_pkg::*; (
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  item_t item,
    input  logic  pop,
    output logic  full,
    output logic  empty,
    output cmd_t  head
);
    cmd_t        q_reg [2];
    logic [1:0]  cnt_reg, cnt_next;
    logic        rd_reg;
    logic        wr_reg;
    cmd_t        c;
    logic [TICK_WIDTH-1:0] t;

    always_comb
    begin
        if (TICK_WIDTH < 32 && item.period > 32'(TICK_MAX))
            t = TICK_MAX;
        else
            t = TICK_WIDTH'(item.period);
        if (item.action && item.reload && t == '0)
            t = TICK_WIDTH'(1);
        c.is_add = item.action;
        c.ticks  = t;
        c.reload = item.reload;
        c.tag    = item.tag;
    end

    assign full     = cnt_reg == 2'd2;
    assign empty    = cnt_reg == 2'd0;
    assign head     = q_reg[rd_reg];
    assign cnt_next = cnt_reg + 2'(push && !full) - 2'(pop && !empty);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            rd_reg  <= 1'b0;
            wr_reg  <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (push && !full)
                wr_reg <= ~wr_reg;
            if (pop && !empty)
                rd_reg <= ~rd_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push && !full)
            q_reg[wr_reg] <= c;
    end
endmodule

// ===== rtl/dltq_engine.sv =====
// ---------------------------------------------------------------------------
// dltq_engine: list engine
// Walk and relink the two delta lists; emit one result per cycle at most.
// ---------------------------------------------------------------------------
module dltq_engine import dltq_pkg::*; (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    cmd_valid,
    input  cmd_t    cmd,
    output logic    cmd_pop,
    output logic    res_strobe,
    output result_t res
);
    state_t state_reg, state_next;

    logic [TICK_WIDTH-1:0] delta_reg  [TIMER_SLOTS];
    logic [SLOT_W-1:0]     nxt_reg    [TIMER_SLOTS];
    logic [15:0]           tag_reg    [TIMER_SLOTS];
    logic [TICK_WIDTH-1:0] per_reg    [TIMER_SLOTS];
    logic                  rel_reg    [TIMER_SLOTS];
    logic [TIMER_SLOTS-1:0] used_reg;
    logic [SLOT_W-1:0]     os_head_reg, rl_head_reg;

    cmd_t                  cmd_reg;
    logic [RCNT_W-1:0]     k_reg;
    logic [SLOT_W-1:0]     s_reg, cur_reg, prev_reg;
    logic [TICK_WIDTH-1:0] d_reg;
    logic [SLOT_W-1:0]     walk_n_reg;
    logic                  ins_rl_reg;   // insert into reload list
    logic                  from_tick_reg;
    logic                  res_v_reg;
    result_t               res_reg;

    result_t               pend_reg;
    logic                  pend_v_reg;
    logic                  flag_now;
    result_t               out_reg;
    logic                  out_v_reg;

    // lowest free slot
    logic [SLOT_W-1:0] free_s;
    always_comb
    begin
        free_s = NIL;
        for (int i = TIMER_SLOTS - 1; i >= 0; i--)
            if (!used_reg[i])
                free_s = SLOT_W'(i);
    end

    wire [SIDX_W-1:0] os_i  = os_head_reg[SIDX_W-1:0];
    wire [SIDX_W-1:0] rl_i  = rl_head_reg[SIDX_W-1:0];
    wire [SIDX_W-1:0] cur_i = cur_reg[SIDX_W-1:0];
    wire [SIDX_W-1:0] s_i   = s_reg[SIDX_W-1:0];
    wire [SIDX_W-1:0] prv_i = prev_reg[SIDX_W-1:0];
    wire [SIDX_W-1:0] fr_i  = free_s[SIDX_W-1:0];

    wire os_exp = k_reg < RCNT_W'(MAX_RESULTS) && os_head_reg != NIL
                  && delta_reg[os_i] == '0;
    wire rl_exp = k_reg < RCNT_W'(MAX_RESULTS) && rl_head_reg != NIL
                  && delta_reg[rl_i] == '0;
    wire walk_go = cur_reg != NIL && walk_n_reg < SLOT_W'(TIMER_SLOTS)
                   && delta_reg[cur_i] < d_reg;

    assign res_strobe = out_v_reg;
    assign res        = out_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd_pop    = 1'b0;
        unique case (state_reg)
            ST_IDLE:
                if (cmd_valid)
                begin
                    cmd_pop    = 1'b1;
                    state_next = cmd.is_add ? ST_ADD : ST_DEC;
                end
            ST_ADD:
                state_next = (free_s == NIL) ? ST_DONE : ST_INS_INIT;
            ST_DEC:      state_next = ST_EXP_OS;
            ST_EXP_OS:   if (!os_exp) state_next = ST_EXP_RL;
            ST_EXP_RL:   state_next = rl_exp ? ST_INS_INIT : ST_RL_FLAG;
            ST_RL_FLAG:  state_next = ST_DONE;
            ST_INS_INIT: state_next = ST_INS_WALK;
            ST_INS_WALK: if (!walk_go) state_next = ST_INS_LINK;
            ST_INS_LINK: state_next = from_tick_reg ? ST_EXP_RL : ST_DONE;
            ST_DONE:     state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            used_reg    <= '0;
            os_head_reg <= NIL;
            rl_head_reg <= NIL;
            res_v_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            res_v_reg <= 1'b0;
            unique case (state_reg)
                ST_ADD:
                    if (free_s == NIL)
                    begin
                        res_v_reg <= 1'b1;
                    end
                    else
                    begin
                        used_reg[fr_i] <= 1'b1;
                        res_v_reg      <= 1'b1;
                    end
                ST_EXP_OS:
                    if (os_exp)
                    begin
                        os_head_reg      <= nxt_reg[os_i];
                        used_reg[os_i]   <= 1'b0;
                        res_v_reg        <= 1'b1;
                    end
                ST_EXP_RL:
                    if (rl_exp)
                    begin
                        rl_head_reg <= nxt_reg[rl_i];
                        res_v_reg   <= 1'b1;
                    end
                ST_INS_LINK:
                    if (prev_reg == NIL)
                    begin
                        if (ins_rl_reg)
                            rl_head_reg <= s_reg;
                        else
                            os_head_reg <= s_reg;
                    end
                default: ;
            endcase
        end
    end

    // Datapath: slot storage and walk registers, no reset needed.
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
                if (cmd_valid)
                begin
                    cmd_reg       <= cmd;
                    k_reg         <= '0;
                    from_tick_reg <= !cmd.is_add;
                end
            ST_ADD:
            begin
                res_reg.kind        <= (free_s == NIL) ? KIND_FULL : KIND_ADDED;
                res_reg.expired_tag <= cmd_reg.tag;
                res_reg.was_reload  <= cmd_reg.reload;
                res_reg.last        <= 1'b1;
                if (free_s != NIL)
                begin
                    tag_reg[fr_i] <= cmd_reg.tag;
                    per_reg[fr_i] <= cmd_reg.ticks;
                    rel_reg[fr_i] <= cmd_reg.reload;
                    s_reg         <= free_s;
                    d_reg         <= cmd_reg.ticks;
                    ins_rl_reg    <= cmd_reg.reload;
                end
            end
            ST_DEC:
            begin
                if (os_head_reg != NIL && delta_reg[os_i] != '0)
                    delta_reg[os_i] <= delta_reg[os_i] - 1'b1;
                if (rl_head_reg != NIL && delta_reg[rl_i] != '0)
                    delta_reg[rl_i] <= delta_reg[rl_i] - 1'b1;
            end
            ST_EXP_OS:
                if (os_exp)
                begin
                    res_reg.kind        <= KIND_EXPIRED;
                    res_reg.expired_tag <= tag_reg[os_i];
                    res_reg.was_reload  <= 1'b0;
                    res_reg.last        <= 1'b0;
                    k_reg               <= k_reg + 1'b1;
                end
            ST_EXP_RL:
                if (rl_exp)
                begin
                    res_reg.kind        <= KIND_EXPIRED;
                    res_reg.expired_tag <= tag_reg[rl_i];
                    res_reg.was_reload  <= 1'b1;
                    res_reg.last        <= 1'b0;
                    k_reg               <= k_reg + 1'b1;
                    s_reg               <= rl_head_reg;
                    ins_rl_reg          <= 1'b1;
                    d_reg               <= (per_reg[rl_i] == '0) ? TICK_WIDTH'(1)
                                                                 : per_reg[rl_i];
                end
            ST_INS_INIT:
            begin
                prev_reg   <= NIL;
                cur_reg    <= ins_rl_reg ? rl_head_reg : os_head_reg;
                walk_n_reg <= '0;
            end
            ST_INS_WALK:
                if (walk_go)
                begin
                    d_reg      <= d_reg - delta_reg[cur_i];
                    prev_reg   <= cur_reg;
                    cur_reg    <= nxt_reg[cur_i];
                    walk_n_reg <= walk_n_reg + 1'b1;
                end
            ST_INS_LINK:
            begin
                delta_reg[s_i] <= d_reg;
                nxt_reg[s_i]   <= (cur_reg > NIL) ? NIL : cur_reg;
                if (cur_reg < NIL)
                    delta_reg[cur_i] <= delta_reg[cur_i] - d_reg;
                if (prev_reg != NIL)
                    nxt_reg[prv_i] <= s_reg;
            end
            default: ;
        endcase
    end

    // Each expiry of a tick is held until the next one arrives; the final one
    // is sent from the held result with last set when ST_RL_FLAG is reached.
    assign flag_now = state_reg == ST_RL_FLAG;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pend_v_reg <= 1'b0;
        else if (res_v_reg && res_reg.kind == KIND_EXPIRED)
            pend_v_reg <= 1'b1;
        else if (flag_now)
            pend_v_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (res_v_reg && res_reg.kind == KIND_EXPIRED)
            pend_reg <= res_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_v_reg <= 1'b0;
        else
            out_v_reg <= (res_v_reg && res_reg.kind != KIND_EXPIRED)
                      || (res_v_reg && pend_v_reg)
                      || (flag_now && (pend_v_reg || res_v_reg));
    end

    always_ff @(posedge clk)
    begin
        if (res_v_reg && res_reg.kind != KIND_EXPIRED)
            out_reg <= res_reg;
        else if (res_v_reg && pend_v_reg)
            out_reg <= pend_reg;
        else if (flag_now)
            out_reg <= result_t'({pend_reg.kind, pend_reg.expired_tag,
                                  pend_reg.was_reload, 1'b1});
    end
endmodule
